[sv/xml_text_escaper_unit_assert.svh]
// assertion macros for the xml text escaper unit
// expects signals named clock and reset in the including module
`ifndef XML_TEXT_ESCAPER_UNIT_ASSERT_SVH
`define XML_TEXT_ESCAPER_UNIT_ASSERT_SVH

// condition must never hold
`define XTE_ASSERT_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error(msg);

// same-cycle implication
`define XTE_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define XTE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[sv/xte_pkg.sv]
// types, constants and byte functions of the xml text escaper
// no dependencies; imported by every module of the unit
package xte_pkg;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       text_end;
   } req_item_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
      logic       text_done;
   } rsp_item_type;

   typedef enum logic [1:0] {
      JOB_RAW,
      JOB_NAMED,
      JOB_HEX
   } job_kind_type;

   // one output run: raw bytes, a named entity or a numeric reference
   typedef struct packed {
      job_kind_type    kind;
      logic [2:0]      count;
      logic [3:0][7:0] data;
      logic            text_end;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   localparam logic [7:0] CH_AMP  = 8'h26;
   localparam logic [7:0] CH_LT   = 8'h3C;
   localparam logic [7:0] CH_GT   = 8'h3E;
   localparam logic [7:0] CH_APOS = 8'h27;
   localparam logic [7:0] CH_QUOT = 8'h22;
   localparam logic [7:0] CH_HASH = 8'h23;
   localparam logic [7:0] CH_X    = 8'h78;
   localparam logic [7:0] CH_SEMI = 8'h3B;

   // entity length, zero when the byte has no named entity
   function automatic logic [2:0] named_len(logic [7:0] ch);
      logic [2:0] len;
      case (ch)
         CH_AMP:  len = 3'd5;
         CH_LT:   len = 3'd4;
         CH_GT:   len = 3'd4;
         CH_APOS: len = 3'd6;
         CH_QUOT: len = 3'd6;
         default: len = 3'd0;
      endcase
      return len;
   endfunction

   function automatic logic [7:0] named_byte(logic [7:0] ch, logic [2:0] idx);
      logic [47:0] text;
      case (ch)
         CH_AMP:  text = {"&amp;", 8'h00};
         CH_LT:   text = {"&lt;", 16'h0000};
         CH_GT:   text = {"&gt;", 16'h0000};
         CH_APOS: text = "&apos;";
         default: text = "&quot;";
      endcase
      return text[8 * (5 - idx) +: 8];
   endfunction

   function automatic logic [7:0] hex_char(logic [3:0] nib);
      logic [7:0] ch;
      if (nib < 4'd10) begin
         ch = 8'h30 + {4'h0, nib};
      end else begin
         ch = 8'h57 + {4'h0, nib};
      end
      return ch;
   endfunction

   // &#x then one or two lowercase digits then ;
   function automatic logic [7:0] hex_ref_byte(logic [7:0] cp, logic [2:0] idx);
      logic       two;
      logic [7:0] ch;
      two = cp[7:4] != 4'h0;
      case (idx)
         3'd0:    ch = CH_AMP;
         3'd1:    ch = CH_HASH;
         3'd2:    ch = CH_X;
         3'd3:    ch = two ? hex_char(cp[7:4]) : hex_char(cp[3:0]);
         3'd4:    ch = two ? hex_char(cp[3:0]) : CH_SEMI;
         default: ch = CH_SEMI;
      endcase
      return ch;
   endfunction

   function automatic logic needs_numeric(logic [20:0] cp);
      return (cp >= 21'h01 && cp <= 21'h08) || (cp >= 21'h0B && cp <= 21'h0C) ||
             (cp >= 21'h0E && cp <= 21'h1F) || (cp >= 21'h7F && cp <= 21'h84) ||
             (cp >= 21'h86 && cp <= 21'h9F);
   endfunction

endpackage

[sv/xte_front.sv]
// front end: accepts input items, holds utf-8 lead bytes, classifies runs
// depends on xte_pkg; feeds xte_queue
module xte_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  xte_pkg::req_item_type req_item,
   input  logic                 q_full,
   output logic                 push,
   output xte_pkg::job_type     job
);
   import xte_pkg::*;

   logic [7:0] held_ff [3];
   logic [7:0] held_in [3];
   logic [1:0] held_count_ff, held_count_in;
   logic [1:0] need_ff, need_in;

   logic            accept;
   logic [7:0]      b;
   logic            text_end;
   logic            cont;
   logic            hold_path;
   logic [1:0]      eff_count;
   logic [1:0]      lead_need;
   logic [3:0][7:0] buf_bytes;
   logic [2:0]      char_len;
   logic [20:0]     cp;
   logic [2:0]      nlen;
   job_type         char_job;
   job_type         raw_job;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;
   assign b         = req_item.in_byte;
   assign text_end  = req_item.text_end;
   assign cont      = b[7:6] == 2'b10;
   assign hold_path = held_count_ff != 2'd0 && cont;
   assign eff_count = hold_path ? held_count_ff : 2'd0;
   assign char_len  = {1'b0, eff_count} + 3'd1;

   always_comb begin
      if (b >= 8'hC0 && b <= 8'hDF) begin
         lead_need = 2'd1;
      end else if (b >= 8'hE0 && b <= 8'hEF) begin
         lead_need = 2'd2;
      end else if (b >= 8'hF0 && b <= 8'hF7) begin
         lead_need = 2'd3;
      end else begin
         lead_need = 2'd0;
      end
   end

   always_comb begin
      buf_bytes[0] = (eff_count == 2'd0) ? b : held_ff[0];
      buf_bytes[1] = (eff_count == 2'd1) ? b : ((eff_count > 2'd1) ? held_ff[1] : 8'h00);
      buf_bytes[2] = (eff_count == 2'd2) ? b : ((eff_count > 2'd2) ? held_ff[2] : 8'h00);
      buf_bytes[3] = (eff_count == 2'd3) ? b : 8'h00;
   end

   always_comb begin
      case (char_len)
         3'd1:    cp = {13'h0, buf_bytes[0]};
         3'd2:    cp = {10'h0, buf_bytes[0][4:0], buf_bytes[1][5:0]};
         3'd3:    cp = {5'h0, buf_bytes[0][3:0], buf_bytes[1][5:0], buf_bytes[2][5:0]};
         default: cp = {buf_bytes[0][2:0], buf_bytes[1][5:0], buf_bytes[2][5:0],
                        buf_bytes[3][5:0]};
      endcase
   end

   assign nlen = named_len(b);

   always_comb begin
      raw_job.kind     = JOB_RAW;
      raw_job.count    = char_len;
      raw_job.data     = buf_bytes;
      raw_job.text_end = text_end;

      char_job = raw_job;
      if (char_len == 3'd1 && nlen != 3'd0) begin
         char_job.kind  = JOB_NAMED;
         char_job.count = nlen;
      end else if (needs_numeric(cp)) begin
         char_job.kind    = JOB_HEX;
         char_job.count   = (cp[7:4] != 4'h0) ? 3'd6 : 3'd5;
         char_job.data[0] = cp[7:0];
      end
   end

   always_comb begin
      held_in       = held_ff;
      held_count_in = held_count_ff;
      need_in       = need_ff;
      push          = 1'b0;
      job           = raw_job;
      if (accept) begin
         if (hold_path) begin
            if (need_ff <= 2'd1) begin
               push          = 1'b1;
               job           = char_job;
               held_count_in = 2'd0;
               need_in       = 2'd0;
            end else if (text_end) begin
               push          = 1'b1;
               held_count_in = 2'd0;
               need_in       = 2'd0;
            end else begin
               held_in[held_count_ff] = b;
               held_count_in          = held_count_ff + 2'd1;
               need_in                = need_ff - 2'd1;
            end
         end else begin
            held_count_in = 2'd0;
            need_in       = 2'd0;
            if (lead_need == 2'd0) begin
               push = 1'b1;
               if (!(cont || b >= 8'hF8)) begin
                  job = char_job;
               end
            end else if (text_end) begin
               push = 1'b1;
            end else begin
               held_in[0]    = b;
               held_count_in = 2'd1;
               need_in       = lead_need;
            end
         end
         if (text_end) begin
            held_count_in = 2'd0;
            need_in       = 2'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      held_ff <= held_in;
      if (reset) begin
         held_count_ff <= 2'd0;
         need_ff       <= 2'd0;
      end else begin
         held_count_ff <= held_count_in;
         need_ff       <= need_in;
      end
   end

endmodule

[sv/xte_queue.sv]
// short job queue between front and back end
// depends on xte_pkg
module xte_queue #(
   parameter int DEPTH = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  xte_pkg::job_type     push_job,
   input  logic                 pop,
   output xte_pkg::job_type     head_job,
   output xte_pkg::q_status_type status
);
   import xte_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR   = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

   job_type          entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign head_job     = entry_ff[rd_ptr_ff];
   assign status.full  = count_ff == FULL_COUNT;
   assign status.empty = count_ff == '0;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[sv/xte_back.sv]
// back end: walks the head job byte by byte into the output register
// depends on xte_pkg; drains xte_queue
module xte_back (
   input  logic                 clock,
   input  logic                 reset,
   input  xte_pkg::job_type     head_job,
   input  logic                 q_empty,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output xte_pkg::rsp_item_type rsp_item
);
   import xte_pkg::*;

   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_item_ff, rsp_item_in;
   logic [2:0]   idx_ff, idx_in;

   logic       load_ok;
   logic       emit;
   logic       last;
   logic [7:0] byte_sel;

   assign load_ok   = !rsp_valid_ff || !rsp_stall;
   assign emit      = !q_empty && load_ok;
   assign last      = idx_ff == (head_job.count - 3'd1);
   assign pop       = emit && last;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   always_comb begin
      unique case (head_job.kind)
         JOB_RAW:   byte_sel = head_job.data[idx_ff[1:0]];
         JOB_NAMED: byte_sel = named_byte(head_job.data[0], idx_ff);
         JOB_HEX:   byte_sel = hex_ref_byte(head_job.data[0], idx_ff);
         default:   byte_sel = head_job.data[idx_ff[1:0]];
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_item_in  = rsp_item_ff;
      idx_in       = idx_ff;
      if (emit) begin
         rsp_valid_in          = 1'b1;
         rsp_item_in.out_byte  = byte_sel;
         rsp_item_in.run_last  = last;
         rsp_item_in.text_done = last && head_job.text_end;
         idx_in                = last ? 3'd0 : idx_ff + 3'd1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff <= rsp_item_in;
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         idx_ff       <= 3'd0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
      end
   end

endmodule

[sv/xml_text_escaper_unit.sv]
// top level of the xml text escaper: front end, job queue, back end
// depends on xte_pkg, xte_front, xte_queue, xte_back and the assert header
//
//   channel  dir  handshake            payload
//   req      in   req_valid/req_stall  xte_pkg::req_item_type
//   rsp      out  rsp_valid/rsp_stall  xte_pkg::rsp_item_type
//
// an item that yields one byte or none passes at one per cycle unless stalled
// an escape yields 4 to 6 bytes, sent by the back end sequencer one per cycle unless stalled
// the queue of QUEUE_DEPTH jobs absorbs bursts; req_stall rises when it is full
// reset clears held lead bytes, the queue and the output valid flag at once
// rsp_stall holds the output register and backs up through the queue
module xml_text_escaper_unit #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  xte_pkg::req_item_type req_item,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output xte_pkg::rsp_item_type rsp_item
);
   import xte_pkg::*;

   logic         push;
   logic         pop;
   job_type      push_job;
   job_type      head_job;
   q_status_type q_status;

   xte_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .q_full    (q_status.full),
      .push      (push),
      .job       (push_job)
   );

   xte_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .status   (q_status)
   );

   xte_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head_job  (head_job),
      .q_empty   (q_status.empty),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

`include "xml_text_escaper_unit_assert.svh"

   `XTE_ASSERT_NEVER(a_no_push_full, push && q_status.full, "job pushed into full queue")
   `XTE_ASSERT_NEXT(a_no_spurious_rsp, q_status.empty && !rsp_valid, !rsp_valid, "item without job")
   `XTE_ASSERT_IMPLY(a_done_is_last, rsp_valid && rsp_item.text_done, rsp_item.run_last, "done not last")

endmodule
